// File: src/rtpp_pkg.sv
// shared types and constants of the rtp packetizer
// used by every module of the block; no dependencies
package rtpp_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_SOURCE_ID      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PAYLOAD_TYPE   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_SEQUENCE = 2'd3;

  // register reset values
  localparam logic [31:0] SOURCE_ID_RST      = 32'd0;
  localparam logic [6:0]  PAYLOAD_TYPE_RST   = 7'd96;
  localparam logic [11:0] MAX_PAYLOAD_RST    = 12'd1400;
  localparam logic [15:0] FIRST_SEQUENCE_RST = 16'd0;

  // rtp header
  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
  localparam int unsigned HdrLen  = 12;
  localparam int unsigned HdrIdxW = $clog2(HdrLen + 1);

  // queue between front and back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // one classified payload byte
  typedef struct packed {
    logic [7:0]  data;
    logic        sop;        // first byte of a packet, header goes before it
    logic        pend;       // last byte of a packet
    logic [15:0] seq;        // sequence number of its packet
    logic [31:0] ts;         // timestamp of the byte's frame
  } rtpp_item_t;

endpackage

// File: src/rtpp_front.sv
// front part: accepts payload bytes, tracks packet fill and sequence number
// depends on rtpp_pkg
module rtpp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_data_i,
  input  logic                in_last_i,
  input  logic [31:0]         in_ts_i,
  input  logic [11:0]         max_payload_i,
  input  logic                seq_load_i,
  input  logic [15:0]         seq_value_i,
  output logic                push_o,
  output rtpp_pkg::rtpp_item_t push_item_o,
  input  logic                full_i
);
  import rtpp_pkg::*;

  logic [11:0] bip_q, bip_d;
  logic [15:0] seq_q, seq_d;
  logic [11:0] bip_inc;
  logic [11:0] limit;
  logic        pend;
  logic        accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // packet end: frame end or byte count reaching the limit
  assign limit   = (max_payload_i == 12'd0) ? 12'd1 : max_payload_i;
  assign bip_inc = bip_q + 12'd1;
  assign pend    = in_last_i || (bip_inc >= limit);

  assign push_o           = accept;
  assign push_item_o.data = in_data_i;
  assign push_item_o.sop  = (bip_q == 12'd0);
  assign push_item_o.pend = pend;
  assign push_item_o.seq  = seq_q;
  assign push_item_o.ts   = in_ts_i;

  // next packet state
  always_comb begin
    bip_d = bip_q;
    seq_d = seq_q;
    if (seq_load_i) begin
      seq_d = seq_value_i;
    end else if (accept) begin
      if (pend) begin
        bip_d = 12'd0;
        seq_d = seq_q + 16'd1;
      end else begin
        bip_d = bip_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bip_q <= 12'd0;
      seq_q <= FIRST_SEQUENCE_RST;
    end else begin
      bip_q <= bip_d;
      seq_q <= seq_d;
    end
  end

endmodule

// File: src/rtpp_fifo.sv
// short queue of classified bytes between front and back
// depends on rtpp_pkg
module rtpp_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rtpp_pkg::rtpp_item_t push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output rtpp_pkg::rtpp_item_t head_o
);
  import rtpp_pkg::*;

  rtpp_item_t            mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_item_i;
  end

endmodule

// File: src/rtpp_back.sv
// back part: emits the payload byte of each queued item, with the rtp header before a packet's first item
// depends on rtpp_pkg
module rtpp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  rtpp_pkg::rtpp_item_t head_i,
  output logic                 pop_o,
  input  logic [31:0]          source_id_i,
  input  logic [6:0]           payload_type_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_is_header_o,
  output logic                 out_packet_end_o,
  output logic                 out_run_end_o
);
  import rtpp_pkg::*;

  logic [HdrIdxW-1:0] hidx_q, hidx_d;
  logic               valid_q, valid_d;
  logic [7:0]         byte_q, byte_d;
  logic               hdr_q, hdr_d;
  logic               pend_q, pend_d;
  logic               rend_q, rend_d;
  logic               load;
  logic               in_hdr;
  logic [7:0]         hdr_byte;

  // output register can take a new transaction
  assign load   = !empty_i && (!valid_q || out_ready_i);
  assign in_hdr = head_i.sop && (hidx_q < HdrIdxW'(HdrLen));
  assign pop_o  = load && !in_hdr;

  // header byte for the current position
  always_comb begin
    unique case (hidx_q)
      4'd0:    hdr_byte = RTP_VERSION_BYTE;
      4'd1:    hdr_byte = {1'b0, payload_type_i};
      4'd2:    hdr_byte = head_i.seq[15:8];
      4'd3:    hdr_byte = head_i.seq[7:0];
      4'd4:    hdr_byte = head_i.ts[31:24];
      4'd5:    hdr_byte = head_i.ts[23:16];
      4'd6:    hdr_byte = head_i.ts[15:8];
      4'd7:    hdr_byte = head_i.ts[7:0];
      4'd8:    hdr_byte = source_id_i[31:24];
      4'd9:    hdr_byte = source_id_i[23:16];
      4'd10:   hdr_byte = source_id_i[15:8];
      4'd11:   hdr_byte = source_id_i[7:0];
      default: hdr_byte = 8'd0;
    endcase
  end

  // next output and header position
  always_comb begin
    hidx_d  = hidx_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    hdr_d   = hdr_q;
    pend_d  = pend_q;
    rend_d  = rend_q;
    if (valid_q && out_ready_i) valid_d = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      if (in_hdr) begin
        byte_d = hdr_byte;
        hdr_d  = 1'b1;
        pend_d = 1'b0;
        rend_d = 1'b0;
        hidx_d = hidx_q + 1'b1;
      end else begin
        byte_d = head_i.data;
        hdr_d  = 1'b0;
        pend_d = head_i.pend;
        rend_d = 1'b1;
        hidx_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hidx_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      hidx_q  <= hidx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    hdr_q  <= hdr_d;
    pend_q <= pend_d;
    rend_q <= rend_d;
  end

  assign out_valid_o      = valid_q;
  assign out_byte_o       = byte_q;
  assign out_is_header_o  = hdr_q;
  assign out_packet_end_o = pend_q;
  assign out_run_end_o    = rend_q;

`ifndef SYNTHESIS
  // header position never runs past the header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hidx_q <= HdrIdxW'(HdrLen))
    else $error("header position out of range");

  // a header byte never closes a run or a packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && hdr_q |-> !rend_q && !pend_q)
    else $error("header byte marked as run or packet end");

  // the last header byte is followed by the payload byte of the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && in_hdr && hidx_q == HdrIdxW'(HdrLen - 1) |=> hidx_q == HdrIdxW'(HdrLen))
    else $error("header sequence broken");

  // an item leaves the queue only after its header is complete
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && head_i.sop |-> hidx_q == HdrIdxW'(HdrLen))
    else $error("payload byte popped before full header");
`endif

endmodule

// File: src/rtp_packetizer_core.sv
// top level of the rtp packetizer: configuration registers, front, queue, back
// depends on rtpp_pkg, rtpp_front, rtpp_fifo, rtpp_back
// path: an accepted byte is registered in the queue, then in the output register, before it appears at the output
// throughput: 1 byte per cycle within a packet while m_axis_tready is high and bytes are queued; a packet's
//   first byte follows the 12 header bytes on the single output byte lane
// reset: async active low; registers take their defaults, counters clear, queue empties
module rtp_packetizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] payload_byte, [39:8] frame_time
  input  logic        s_axis_tlast,   // frame_end
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,   // [0] is_header, [1] packet_end
  output logic        m_axis_tlast    // run_end
);
  import rtpp_pkg::*;

  logic [31:0] source_id_q;
  logic [6:0]  payload_type_q;
  logic [11:0] max_payload_q;
  logic        seq_load;
  logic        cfg_we;
  logic        push, full, pop, empty;
  rtpp_item_t  push_item, head;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign seq_load    = cfg_we && (cfg_index_i == CFG_FIRST_SEQUENCE);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_id_q    <= SOURCE_ID_RST;
      payload_type_q <= PAYLOAD_TYPE_RST;
      max_payload_q  <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_SOURCE_ID:      source_id_q    <= cfg_data_i;
        CFG_PAYLOAD_TYPE:   payload_type_q <= cfg_data_i[6:0];
        CFG_MAX_PAYLOAD:    max_payload_q  <= cfg_data_i[11:0];
        CFG_FIRST_SEQUENCE: ;
        default: ;
      endcase
    end
  end

  rtpp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_data_i     (s_axis_tdata[7:0]),
    .in_last_i     (s_axis_tlast),
    .in_ts_i       (s_axis_tdata[39:8]),
    .max_payload_i (max_payload_q),
    .seq_load_i    (seq_load),
    .seq_value_i   (cfg_data_i[15:0]),
    .push_o        (push),
    .push_item_o   (push_item),
    .full_i        (full)
  );

  rtpp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  rtpp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .head_i           (head),
    .pop_o            (pop),
    .source_id_i      (source_id_q),
    .payload_type_i   (payload_type_q),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_byte_o       (m_axis_tdata),
    .out_is_header_o  (m_axis_tuser[0]),
    .out_packet_end_o (m_axis_tuser[1]),
    .out_run_end_o    (m_axis_tlast)
  );

endmodule
